>>> sv/mstk_pkg.sv
// Package with the types and constants shared by the spanning tree block.
`default_nettype none
package mstk_pkg;

  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [4:0] VERTEX_COUNT_RESET = 5'd16;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [3:0]  column_index;
    logic [15:0] edge_cost;
    logic        last_entry;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  from_vertex;
    logic [3:0]  to_vertex;
    logic [15:0] chosen_weight;
    logic        edge_found;
    logic        last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic round_start;
    logic step;
    logic join_emit;
    logic miss_emit;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic have;
    logic edge_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> sv/minimum_spanning_tree_kruskal.sv
// Top level of the Kruskal minimum spanning tree block with its configuration register.
// Channel  Direction  Payload     Handshake
// in_      input      in_item_t   in_valid / in_ready
// out_     output     out_item_t  out_valid / out_ready
// cfg      input      32-bit APB  psel / penable / pwrite / pready
// Matrix entries are taken one per cycle while the block is idle.
// The entry flagged last starts a run through a setup state; each round scans n*n stored
// weights at one memory read per cycle, and a run takes up to n-1 rounds.
// A result waits in an output register; the next round starts once the register is free.
// Reset is synchronous and active low; the weight memory is not cleared.
`default_nettype none
module minimum_spanning_tree_kruskal #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire mstk_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output mstk_pkg::out_item_t       out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import mstk_pkg::*;

  logic [4:0] vertex_count_r;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VERTEX_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
      vertex_count_r <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {27'd0, vertex_count_r} : 32'd0;

  mstk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_entry),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mstk_dp #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (in_data),
    .vertex_count (vertex_count_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
`default_nettype wire

>>> sv/mstk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mstk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/mstk_ctrl.sv
// Controller state machine that sequences loading, scan rounds and result output.
`default_nettype none
module mstk_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_last,
  output logic                 in_ready,
  input  wire mstk_pkg::sts_t  sts,
  output mstk_pkg::cmd_t       cmd
);
  import mstk_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_last) state_nxt = S_INIT;
      end
      S_INIT:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.scan_end) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          if (!sts.have || sts.edge_last) state_nxt = S_IDLE;
          else state_nxt = S_SCAN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_INIT: begin
        cmd.init = 1'b1;
        cmd.round_start = 1'b1;
      end
      S_SCAN:  cmd.step = 1'b1;
      S_DRAIN: cmd = '0;
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.join_emit = sts.have;
          cmd.miss_emit = !sts.have;
          cmd.round_start = sts.have && !sts.edge_last;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/mstk_dp.sv
// Datapath with the weight memory, scan counters, set labels, ranks and output register.
`default_nettype none
module mstk_dp #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mstk_pkg::cmd_t       cmd,
  output mstk_pkg::sts_t            sts,
  input  wire mstk_pkg::in_item_t   in_data,
  input  wire logic [4:0]           vertex_count,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output mstk_pkg::out_item_t       out_data
);
  import mstk_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int AW = 2 * IW;
  localparam logic [WEIGHT_BITS:0] SENTINEL = (WEIGHT_BITS+1)'(1) << WEIGHT_BITS;

  logic [IW:0]   n, nm1;
  logic [31:0]   n32, row32, col32, cost32;
  logic [IW-1:0] i_r, j_r, id_r, jd_r, pa_r, pb_r;
  logic          vd_r, have_r;
  logic [WEIGHT_BITS:0]   best_r;
  logic [WEIGHT_BITS-1:0] rdata;
  logic [IW:0]   edges_r;
  logic [IW-1:0] lbl_r [MAX_VERTICES];
  logic [2:0]    rank_r [MAX_VERTICES];
  logic          out_valid_r;
  out_item_t     out_data_r;
  logic          hit;
  logic [IW-1:0] ra, rb, win, lose;

  always_comb begin
    if (vertex_count < 5'd2) n32 = 32'd2;
    else if (32'(vertex_count) > MAX_VERTICES) n32 = 32'(MAX_VERTICES);
    else n32 = 32'(vertex_count);
    n = (IW+1)'(n32);
    nm1 = n - (IW+1)'(1);
    row32 = 32'(in_data.row_index);
    col32 = 32'(in_data.column_index);
    cost32 = 32'(in_data.edge_cost);
  end

  mstk_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(1 << AW)) u_ram (
    .clk   (clk),
    .we    (cmd.load && row32 < MAX_VERTICES && col32 < MAX_VERTICES),
    .waddr ({row32[IW-1:0], col32[IW-1:0]}),
    .wdata (cost32[WEIGHT_BITS-1:0]),
    .raddr ({i_r, j_r}),
    .rdata (rdata)
  );

  assign hit = vd_r && (lbl_r[id_r] != lbl_r[jd_r]) && (rdata != '0)
               && ({1'b0, rdata} < best_r);

  always_comb begin
    ra = lbl_r[pa_r];
    rb = lbl_r[pb_r];
    if (rank_r[ra] < rank_r[rb]) begin
      win = rb;
      lose = ra;
    end else begin
      win = ra;
      lose = rb;
    end
  end

  assign sts.scan_end = ({1'b0, i_r} == nm1) && ({1'b0, j_r} == nm1);
  assign sts.have = have_r;
  assign sts.edge_last = (edges_r + (IW+1)'(1)) == nm1;
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      have_r <= 1'b0;
      edges_r <= '0;
      i_r <= '0;
      j_r <= '0;
      best_r <= SENTINEL;
    end else begin
      vd_r <= cmd.step;
      id_r <= i_r;
      jd_r <= j_r;
      if (cmd.step) begin
        if ({1'b0, j_r} == nm1) begin
          j_r <= '0;
          i_r <= i_r + IW'(1);
        end else begin
          j_r <= j_r + IW'(1);
        end
      end
      if (hit) begin
        best_r <= {1'b0, rdata};
        pa_r <= id_r;
        pb_r <= jd_r;
        have_r <= 1'b1;
      end
      if (cmd.join_emit) edges_r <= edges_r + (IW+1)'(1);
      if (cmd.init) edges_r <= '0;
      if (cmd.round_start) begin
        i_r <= '0;
        j_r <= '0;
        best_r <= SENTINEL;
        have_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      if (cmd.init) begin
        lbl_r[k] <= IW'(k);
        rank_r[k] <= 3'd0;
      end else if (cmd.join_emit) begin
        if (lbl_r[k] == lose) lbl_r[k] <= win;
        if (IW'(k) == win && rank_r[ra] == rank_r[rb]) rank_r[k] <= rank_r[k] + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.join_emit || cmd.miss_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.join_emit) begin
      out_data_r.from_vertex <= 4'(32'(pa_r));
      out_data_r.to_vertex <= 4'(32'(pb_r));
      out_data_r.chosen_weight <= 16'(32'(best_r));
      out_data_r.edge_found <= 1'b1;
      out_data_r.last_result <= sts.edge_last;
    end else if (cmd.miss_emit) begin
      out_data_r <= '0;
      out_data_r.last_result <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.join_emit || cmd.miss_emit) |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transaction");
  a_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init |=> (edges_r == '0 && !have_r && lbl_r[MAX_VERTICES-1] == IW'(MAX_VERTICES-1)))
    else $error("run start did not reset the sets");
  a_best: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> (best_r != '0 && best_r < SENTINEL))
    else $error("kept edge has an impossible weight");
`endif

endmodule
`default_nettype wire

>>> tb/mst_edge_checker.sv
// Checker that predicts the spanning tree edges and compares them with the block's results.
`timescale 1ns / 1ps
module mst_edge_checker
  import mstk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          edge_count,
  output int          miss_count
);

  logic [15:0] weights [16][16];
  logic [3:0]  link [16];
  logic [2:0]  depth [16];
  logic [4:0]  vertex_setting;
  out_item_t   expected_edges [$];

  initial begin
    fail_count = 0;
    pending = 0;
    edge_count = 0;
    miss_count = 0;
    vertex_setting = VERTEX_COUNT_RESET;
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 16; j++) begin
        weights[i][j] = '0;
      end
    end
  end

  function automatic logic [3:0] find_root(logic [3:0] v);
    logic [3:0] r;
    logic [3:0] cur;
    logic [3:0] nxt;
    r = v;
    for (int g = 0; g < 16 && link[r] != r; g++) r = link[r];
    cur = v;
    for (int g = 0; g < 16 && cur != r; g++) begin
      nxt = link[cur];
      link[cur] = r;
      cur = nxt;
    end
    return r;
  endfunction

  task automatic build_spanning_tree();
    int n;
    int taken;
    logic [16:0] best;
    logic [3:0] pick_a;
    logic [3:0] pick_b;
    logic [3:0] ra;
    logic [3:0] rb;
    logic have;
    out_item_t e;
    n = vertex_setting;
    if (n < 2) n = 2;
    if (n > 16) n = 16;
    for (int i = 0; i < 16; i++) begin
      link[i] = 4'(i);
      depth[i] = '0;
    end
    taken = 0;
    while (taken < n - 1) begin
      best = 17'h10000;
      have = 1'b0;
      pick_a = '0;
      pick_b = '0;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          if (find_root(4'(i)) != find_root(4'(j)) && weights[i][j] != 0 &&
              {1'b0, weights[i][j]} < best) begin
            best = {1'b0, weights[i][j]};
            pick_a = 4'(i);
            pick_b = 4'(j);
            have = 1'b1;
          end
        end
      end
      if (!have) begin
        e = '{from_vertex: '0, to_vertex: '0, chosen_weight: '0,
              edge_found: 1'b0, last_result: 1'b1};
        expected_edges.push_back(e);
        break;
      end
      ra = find_root(pick_a);
      rb = find_root(pick_b);
      if (depth[ra] < depth[rb]) begin
        link[ra] = rb;
      end else if (depth[ra] > depth[rb]) begin
        link[rb] = ra;
      end else begin
        link[rb] = ra;
        depth[ra] = depth[ra] + 3'd1;
      end
      taken++;
      e = '{from_vertex: pick_a, to_vertex: pick_b, chosen_weight: best[15:0],
            edge_found: 1'b1, last_result: (taken == n - 1)};
      expected_edges.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      vertex_setting <= VERTEX_COUNT_RESET;
      expected_edges.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_VERTEX_COUNT, 2'b00}) begin
        vertex_setting = pwdata[4:0];
      end
      if (in_valid && in_ready) begin
        weights[in_data.row_index][in_data.column_index] = in_data.edge_cost;
        if (in_data.last_entry) build_spanning_tree();
      end
      if (out_valid && out_ready) begin
        if (expected_edges.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_edges.pop_front();
          if (want.edge_found) edge_count <= edge_count + 1;
          else miss_count <= miss_count + 1;
          if (out_data.from_vertex !== want.from_vertex ||
              out_data.to_vertex !== want.to_vertex ||
              out_data.chosen_weight !== want.chosen_weight ||
              out_data.edge_found !== want.edge_found ||
              out_data.last_result !== want.last_result) begin
            $display("%0t: result differs, expected %p, got %p", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_edges.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// Top of the testbench: clock, reset, stimulus and verdict for the spanning tree block.
`timescale 1ns / 1ps
module tb_top;
  import mstk_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_data = '0;
  logic        out_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        in_ready;
  logic        out_valid;
  out_item_t   out_data;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          edge_count;
  int          miss_count;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          entries_sent = 0;
  int          runs = 0;
  int          cycles = 0;
  int          n_eff = 16;

  minimum_spanning_tree_kruskal uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mst_edge_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending),
    .edge_count(edge_count), .miss_count(miss_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("minimum_spanning_tree_kruskal: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(1, 100) > recv_stall_pct);
  end

  task automatic send_entry(input logic [3:0] r, input logic [3:0] c,
                            input logic [15:0] w, input logic last);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{row_index: r, column_index: c, edge_cost: w, last_entry: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    entries_sent++;
    if (last) runs++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_vertex_count(input logic [4:0] value);
    wait_idle();
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_VERTEX_COUNT, 2'b00};
    pwdata <= {27'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    n_eff = (value < 2) ? 2 : (value > 16) ? 16 : value;
  endtask

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(0, 9))
      0, 1: return 16'h0000;
      2: return 16'hFFFF;
      3, 4, 5: return 16'($urandom_range(1, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_run();
    int count;
    logic [3:0] r;
    logic [3:0] c;
    case ($urandom_range(0, 9))
      0: set_vertex_count($urandom_range(0, 1) ? 5'($urandom_range(0, 1))
                                                : 5'($urandom_range(17, 31)));
      1: set_vertex_count(5'($urandom_range(7, 16)));
      default: set_vertex_count(5'($urandom_range(2, 6)));
    endcase
    count = $urandom_range(1, 2 * n_eff);
    for (int k = 0; k <= count; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        r = 4'($urandom);
        c = 4'($urandom);
      end else begin
        r = 4'($urandom_range(0, n_eff - 1));
        c = 4'($urandom_range(0, n_eff - 1));
      end
      send_entry(r, c, pick_cost(), k == count);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill the whole matrix once so that no scan reads an unwritten weight.
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 16; j++) begin
        send_entry(4'(i), 4'(j), pick_cost(), i == 15 && j == 15);
      end
    end

    set_vertex_count(5'd2);
    send_entry(4'd1, 4'd0, 16'h0000, 1'b0);
    send_entry(4'd0, 4'd1, 16'hFFFF, 1'b1);
    set_vertex_count(5'd3);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        send_entry(4'(i), 4'(j), 16'h0000, i == 2 && j == 2);
      end
    end
    set_vertex_count(5'd0);
    send_entry(4'd1, 4'd0, 16'd5, 1'b1);
    set_vertex_count(5'd31);
    send_entry(4'd15, 4'd15, 16'hFFFF, 1'b0);
    send_entry(4'd15, 4'd0, 16'd1, 1'b0);
    send_entry(4'd0, 4'd15, 16'd1, 1'b1);
    set_vertex_count(5'd16);
    send_entry(4'd14, 4'd3, 16'd2, 1'b1);

    for (int mode = 0; mode < 4; mode++) begin
      wait_idle();
      send_idle_pct = (mode == 1) ? 80 : (mode == 3) ? 10 : 0;
      recv_stall_pct = (mode == 2) ? 80 : (mode == 3) ? 10 : 0;
      while (entries_sent < 300 + 50 * (mode + 1)) random_run();
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Ran %0d spanning tree runs from %0d matrix entries across four idling phases.",
             runs, entries_sent);
    $display("Checked %0d tree edges and %0d disconnected-graph endings.",
             edge_count, miss_count);
    if (fail_count == 0 && pending == 0) begin
      $display("minimum_spanning_tree_kruskal: match");
    end else begin
      $display("minimum_spanning_tree_kruskal: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
sv/mstk_pkg.sv
sv/mstk_ram.sv
sv/mstk_ctrl.sv
sv/mstk_dp.sv
sv/minimum_spanning_tree_kruskal.sv
tb/mst_edge_checker.sv
tb/tb_top.sv
